// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files, included by dcc_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_AT(lbl, clk, rst, !(cond))
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- src/dcc_pkg.sv -----
// Shared constants, types and codes of the distance constraint chain.
package dcc_pkg;
  localparam int MAX_JOINTS = 16;
  localparam int IDX_W      = $clog2(MAX_JOINTS);
  localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
  localparam int COORD_W    = 24;
  localparam int RAD_W      = 23;
  localparam int JIN_W      = 4;
  localparam int CFG_W      = 5;
  localparam int DIFF_W     = 25;
  localparam int MAG_W      = 25;
  localparam int SQ_W       = 50;
  localparam int STSQ_W     = 46;
  localparam int ROOT_IN_W  = 62;
  localparam int LEN_W      = 31;
  localparam int PROD_W     = 48;
  localparam int DIVD_W     = 56;
  localparam int DIVS_W     = 32;
  localparam int QUO_W      = 24;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_W-1:0] JC_RESET = 5'd4;
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FRAME = 1'b1;
  localparam logic REG_JOINT_COUNT = 1'b0;

  typedef struct packed {
    logic               is_frame;
    logic               load_ok;
    logic [JIN_W-1:0]   joint_index;
    logic [COORD_W-1:0] load_x;
    logic [COORD_W-1:0] load_y;
    logic [RAD_W-1:0]   load_radius;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [RAD_W-1:0]   step_limit;
  } q_item_t;
endpackage

// ----- src/dcc_front.sv -----
// Input side: accept transfers, classify them and queue them for the sequencer.
module dcc_front import dcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // joint_index, load_x, load_y, load_radius, target_x, target_y, step_limit
  input  logic [IN_DATA_W-1:0] s_tdata,
  // action
  input  logic                 s_tuser,
  output logic                 q_valid,
  output q_item_t              q_item,
  input  logic                 q_pop
);
  q_item_t    mem [2];
  q_item_t    item;
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  always_comb begin
    item.is_frame    = (s_tuser == ACT_FRAME);
    item.load_ok     = (32'(s_tdata[3:0]) < MAX_JOINTS);
    item.joint_index = s_tdata[3:0];
    item.load_x      = s_tdata[27:4];
    item.load_y      = s_tdata[51:28];
    item.load_radius = s_tdata[74:52];
    item.target_x    = s_tdata[98:75];
    item.target_y    = s_tdata[122:99];
    item.step_limit  = s_tdata[145:123];
  end

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/dcc_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
module dcc_sqrt import dcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ROOT_IN_W-1:0] radicand,
  output logic                 done,
  output logic [LEN_W-1:0]     root
);
  logic [ROOT_IN_W-1:0] rem, res, bitv, trial;
  logic                 busy;

  assign trial = res + bitv;
  assign root  = res[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bitv == ROOT_IN_W'(1));
      if (start) busy <= 1'b1;
      else if (bitv == ROOT_IN_W'(1)) busy <= 1'b0;
    end
  end
endmodule

// ----- src/dcc_div.sv -----
// Restoring divider, one quotient bit per cycle; the quotient must fit QUO_W bits.
module dcc_div import dcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);
  localparam int CW = $clog2(QUO_W);

  logic [DIVS_W-1:0] rem, dsr;
  logic [QUO_W-1:0]  sh;
  logic [CW-1:0]     cnt;
  logic              busy, ge;
  logic [DIVS_W:0]   trial, diff;

  assign trial    = {rem, sh[QUO_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DIVD_W-1:QUO_W];
      sh  <= dividend[QUO_W-1:0];
      dsr <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      sh  <= {sh[QUO_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(QUO_W - 1));
      if (start) busy <= 1'b1;
      else if (cnt == CW'(QUO_W - 1)) busy <= 1'b0;
    end
  end
endmodule

// ----- src/dcc_back.sv -----
// Sequencer: joint storage, load and frame execution, result output register.
module dcc_back import dcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CFG_W-1:0]      joint_count,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);
  `include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_MULN  = 4'd5;
  localparam logic [3:0] ST_DSTRT = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0] state;

  logic [COORD_W-1:0] xs [MAX_JOINTS];
  logic [COORD_W-1:0] ys [MAX_JOINTS];
  logic [RAD_W-1:0]   rs [MAX_JOINTS];

  logic [IDX_W-1:0]   cur;
  logic [CNT_W-1:0]   n;
  logic [COORD_W-1:0] tx, ty, px, py, cx, cy;
  logic [RAD_W-1:0]   step, pr, nr;
  logic [DIFF_W-1:0]  dx, dy;
  logic [SQ_W-1:0]    sqx, sqy, ssum;
  logic [STSQ_W-1:0]  stsq;
  logic [LEN_W-1:0]   len;
  logic [PROD_W-1:0]  prx, pry;

  logic [MAG_W-1:0]   magx, magy;
  logic [RAD_W-1:0]   bval;
  logic               head, last_joint;

  logic               sq_start, sq_done, dv_start, dvx_done, dvy_done;
  logic [LEN_W-1:0]   root;
  logic [QUO_W-1:0]   qx, qy;
  logic [DIVD_W-1:0]  dvx_n, dvy_n;
  logic [DIVS_W-1:0]  dv_d;

  logic               place;
  logic [COORD_W-1:0] wx, wy;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [COORD_W-1:0] wdx, wdy;
  logic [RAD_W-1:0]   wdr;
  logic               wr_rad;

  logic               out_load;
  logic [JIN_W-1:0]   out_idx;
  logic [COORD_W-1:0] out_x, out_y;
  logic [CNT_W-1:0]   jc_clamped;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] base,
                                                 input logic [QUO_W-1:0] q,
                                                 input logic neg);
    logic signed [DIFF_W-1:0] off;
    logic signed [DIFF_W:0]   sum;
    off = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = $signed({{2{base[COORD_W-1]}}, base}) + $signed({off[DIFF_W-1], off});
    if (sum > $signed((DIFF_W+1)'(8388607)))       return 24'h7FFFFF;
    else if (sum < -$signed((DIFF_W+1)'(8388608))) return 24'h800000;
    else                                           return sum[COORD_W-1:0];
  endfunction

  assign head       = (cur == '0);
  assign last_joint = (CNT_W'(cur) + CNT_W'(1) == n);
  assign magx       = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign magy       = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
  assign bval       = head ? step : pr;
  assign ssum       = sqx + sqy;

  always_comb begin
    if (joint_count == '0)                    jc_clamped = CNT_W'(1);
    else if (32'(joint_count) > MAX_JOINTS)   jc_clamped = CNT_W'(MAX_JOINTS);
    else                                      jc_clamped = CNT_W'(joint_count);
  end

  assign sq_start = (state == ST_CHECK) && (ssum != '0) &&
                    !(head && (ssum <= SQ_W'(stsq)));
  assign dv_start = (state == ST_DSTRT);
  assign dvx_n    = DIVD_W'({prx, 7'b0}) + DIVD_W'(len);
  assign dvy_n    = DIVD_W'({pry, 7'b0}) + DIVD_W'(len);
  assign dv_d     = {len, 1'b0};

  dcc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand({ssum, 12'b0}),
    .done(sq_done), .root(root)
  );
  dcc_div u_div_x (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dvx_n), .divisor(dv_d),
    .done(dvx_done), .quotient(qx)
  );
  dcc_div u_div_y (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dvy_n), .divisor(dv_d),
    .done(dvy_done), .quotient(qy)
  );

  // place the current joint: skip, land on target, or scaled offset from the base
  always_comb begin
    place = 1'b0;
    wx    = cx;
    wy    = cy;
    if (state == ST_CHECK && !sq_start) begin
      place = 1'b1;
      if (ssum != '0) begin
        wx = tx;
        wy = ty;
      end
    end else if (state == ST_DIV && dvx_done) begin
      place = 1'b1;
      wx    = sat_add(head ? cx : px, qx, dx[DIFF_W-1]);
      wy    = sat_add(head ? cy : py, qy, dy[DIFF_W-1]);
    end
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    we     = 1'b0;
    wr_rad = 1'b0;
    waddr  = cur;
    wdx    = wx;
    wdy    = wy;
    wdr    = q_item.load_radius;
    if (q_pop && !q_item.is_frame) begin
      we     = q_item.load_ok;
      wr_rad = q_item.load_ok;
      waddr  = IDX_W'(q_item.joint_index);
      wdx    = q_item.load_x;
      wdy    = q_item.load_y;
    end else if (place) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_JOINTS; k++) begin
        xs[k] <= '0;
        ys[k] <= '0;
        rs[k] <= '0;
      end
    end else if (we) begin
      xs[waddr] <= wdx;
      ys[waddr] <= wdy;
      if (wr_rad) rs[waddr] <= wdr;
    end
  end

  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= '0;
      n        <= CNT_W'(1);
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      // load the next result or drop the one just taken
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop && q_item.is_frame) begin
            n     <= jc_clamped;
            cur   <= '0;
            state <= ST_DIFF;
          end
        end
        ST_DIFF:  state <= ST_SQ;
        ST_SQ:    state <= ST_CHECK;
        ST_CHECK: if (sq_start) state <= ST_ROOT;
        ST_ROOT:  if (sq_done) state <= ST_MULN;
        ST_MULN:  state <= ST_DSTRT;
        ST_DSTRT: state <= ST_DIV;
        ST_DIV:   ;
        ST_EMIT: begin
          if (out_load) begin
            m_tlast <= last_joint;
            if (last_joint) state <= ST_IDLE;
            else cur <= cur + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (place) begin
        if (last_joint) begin
          cur   <= '0;
          state <= ST_EMIT;
        end else begin
          cur   <= cur + 1'b1;
          state <= ST_DIFF;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_frame) begin
      tx   <= q_item.target_x;
      ty   <= q_item.target_y;
      step <= q_item.step_limit;
    end
    if (state == ST_DIFF) begin
      cx <= xs[cur];
      cy <= ys[cur];
      nr <= rs[cur];
      if (head) begin
        dx <= {tx[COORD_W-1], tx} - {xs[cur][COORD_W-1], xs[cur]};
        dy <= {ty[COORD_W-1], ty} - {ys[cur][COORD_W-1], ys[cur]};
      end else begin
        dx <= {xs[cur][COORD_W-1], xs[cur]} - {px[COORD_W-1], px};
        dy <= {ys[cur][COORD_W-1], ys[cur]} - {py[COORD_W-1], py};
      end
    end
    if (state == ST_SQ) begin
      sqx  <= magx * magx;
      sqy  <= magy * magy;
      stsq <= step * step;
    end
    if (state == ST_ROOT && sq_done) len <= root;
    if (state == ST_MULN) begin
      prx <= magx * bval;
      pry <= magy * bval;
    end
    if (place) begin
      px <= wx;
      py <= wy;
      pr <= nr;
    end
    if (out_load) begin
      out_idx <= JIN_W'(cur);
      out_x   <= xs[cur];
      out_y   <= ys[cur];
    end
  end

  assign m_tdata = {4'b0, out_y, out_x, out_idx};

  `ASSERT_NEVER(a_pop_busy, clk, rst, q_pop && (state != ST_IDLE))
  `ASSERT_AT(a_cur_range, clk, rst, (state != ST_IDLE) |-> (CNT_W'(cur) < n))
  `ASSERT_AT(a_div_pair, clk, rst, dvx_done == dvy_done)
  `ASSERT_AT(a_last_idx, clk, rst,
             (m_tvalid && m_tlast) |-> (out_idx == JIN_W'(n - CNT_W'(1))))
endmodule

// ----- src/distance_constraint_chain_unit.sv -----
// Top level of the distance constraint chain: configuration register and block wiring.
//
// Input stream s_*: one transfer per item. s_tuser is the action: a load writes one
// joint (position and radius) and returns nothing; a frame moves the head toward
// the target by at most step_limit, drags each later joint onto the previous
// joint's radius, then sends one result per joint in use on m_*, joint 0 first,
// with m_tlast on the final one.
// A two-entry queue sits behind s_tready, so items are taken while a frame runs
// or while results wait. Items are carried out one at a time, in order.
// A frame works through the joints in turn. A joint that is skipped or lands on the
// target needs no square root; any other joint runs a 31-step square root and a
// 24-step divide (x and y dividers run side by side), with setup and multiply
// steps around them. The results are sent once all joints are placed.
// m_tdata is held in an output register; when m_tready is low the sequencer
// holds the next result and the queue fills, after which s_tready drops.
// Reset (rst, synchronous) clears all joints to zero, sets joint_count to 4 and
// empties the queue; no clearing pass follows. The user writes joint_count through
// the APB port (paddr 0-3) only while the block is idle; the block does not check it.
module distance_constraint_chain_unit import dcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // joint_index, load_x, load_y, load_radius, target_x, target_y, step_limit
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_index, out_x, out_y
  output logic [OUT_DATA_W-1:0] m_tdata,
  // out_last
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  logic [CFG_W-1:0] joint_count;
  logic             q_valid, q_pop;
  q_item_t          q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_JOINT_COUNT) ? 32'(joint_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= JC_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_JOINT_COUNT) begin
      joint_count <= pwdata[CFG_W-1:0];
    end
  end

  dcc_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  dcc_back u_back (
    .clk(clk), .rst(rst), .joint_count(joint_count),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule
